// ===== sv/bblur_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_pkg: shared types and constants of the 3x3 RGB box blur
// Field widths, register codes, the front-to-back control record and the
// reciprocal table used for the rounded mean.
// ----------------------------------------------------------------------------
package bblur_pkg;

	localparam int MAX_WIDTH_DEF = 1024;
	localparam int MAX_HEIGHT    = 4096;

	localparam int FW_W      = 11;
	localparam int FH_W      = 13;
	localparam int ROW_W     = 13;   // rows run up to MAX_HEIGHT + 1 while flushing
	localparam int CFG_W     = 13;
	localparam int CFG_IDX_W = 1;

	localparam int FRAME_WIDTH_RST  = 1024;
	localparam int FRAME_HEIGHT_RST = 1024;

	localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'b1;

	localparam logic CMD_DRAIN = 1'b1;

	localparam int CH_W     = 8;
	localparam int PIX_W    = 3 * CH_W;
	localparam int SUM_W    = 12;    // nine 8-bit values
	localparam int CNT_W    = 4;     // neighbour count, 1 to 9
	localparam int NUM_W    = 13;    // 2 * sum + count
	localparam int RECIP_W  = 18;
	localparam int RECIP_SH = 18;

	localparam int QUEUE_DEPTH = 4;

	typedef struct packed {
		logic       emit;    // item produces a result
		logic       last;    // result is the final pixel of the frame
		logic [2:0] row_ok;  // window rows inside the frame
		logic [2:0] col_ok;  // window columns inside the frame
	} bblur_ctl_t;

	// ceil(2^RECIP_SH / (2 * cnt)); exact floor division for numerators below 2^NUM_W
	function automatic logic [RECIP_W-1:0] recip_of(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		unique case (cnt)
			4'd2:    r = 18'd65536;
			4'd3:    r = 18'd43691;
			4'd4:    r = 18'd32768;
			4'd6:    r = 18'd21846;
			4'd9:    r = 18'd14564;
			default: r = 18'd131072;
		endcase
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/box_blur_3x3_rgb_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// box_blur_3x3_rgb_core: streaming 3x3 box blur of an RGB frame
// Replaces each pixel by the rounded mean of its in-frame 3x3 neighbours.
// ----------------------------------------------------------------------------
// Input requests carry one pixel in raster order (cmd pixel) or a drain tick.
// Each request is taken when in_valid is high and in_stall low; the blurred
// pixel for position q leaves with the request that brings position q+W+1,
// so after the last pixel W+1 drain requests flush the frame. Drain ticks
// inside the frame are dropped; pixels sent during the flush are ignored.
// A result is taken when out_valid is high and out_stall low; frame_end
// marks the last pixel of the frame, after which a new frame starts.
// Throughput: one request per cycle while in_stall is low, set by the line
// store, which does one read and one write per cycle. A four-entry queue
// sits between intake and the back pipeline; while a held result meets
// out_stall, the back pipeline freezes and in_stall rises once the queue
// fills.
// Size registers are written through cfg_write/cfg_index/cfg_data and
// restart the frame. Reset sets a 1024 x 1024 frame and clears the position;
// the line store is not cleared.
// ----------------------------------------------------------------------------
module box_blur_3x3_rgb_core #(
	parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_write,
	input  wire logic [bblur_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bblur_pkg::CFG_W-1:0]       cfg_data,
	input  wire logic                              in_valid,
	output logic                                   in_stall,
	input  wire logic                              cmd,
	input  wire logic [bblur_pkg::CH_W-1:0]        red_in,
	input  wire logic [bblur_pkg::CH_W-1:0]        green_in,
	input  wire logic [bblur_pkg::CH_W-1:0]        blue_in,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [bblur_pkg::CH_W-1:0]             red_out,
	output logic [bblur_pkg::CH_W-1:0]             green_out,
	output logic [bblur_pkg::CH_W-1:0]             blue_out,
	output logic                                   frame_end
);
	import bblur_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int CTL_W  = $bits(bblur_ctl_t);
	localparam int DATA_W = COL_W + PIX_W + CTL_W;

	logic              push_valid;
	logic [COL_W-1:0]  push_col;
	logic [PIX_W-1:0]  push_px;
	bblur_ctl_t        push_ctl;
	logic              q_full;
	logic              q_pop;
	logic              q_valid;
	logic [DATA_W-1:0] q_data;
	logic [COL_W-1:0]  q_col;
	logic [PIX_W-1:0]  q_px;
	bblur_ctl_t        q_ctl;

	assign in_stall = q_full;

	bblur_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_stall   (q_full),
		.cmd        (cmd),
		.red_in     (red_in),
		.green_in   (green_in),
		.blue_in    (blue_in),
		.push_valid (push_valid),
		.push_col   (push_col),
		.push_px    (push_px),
		.push_ctl   (push_ctl)
	);

	bblur_queue #(
		.DATA_W (DATA_W)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push_valid),
		.push_data ({push_col, push_px, push_ctl}),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (q_data)
	);

	assign {q_col, q_px, q_ctl} = q_data;

	bblur_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_col     (q_col),
		.q_px      (q_px),
		.q_ctl     (q_ctl),
		.q_pop     (q_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.frame_end (frame_end)
	);

endmodule
`default_nettype wire

// ===== sv/bblur_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_front: request intake and classification
// Holds the frame size registers and the input position, drops drain
// requests inside the frame, and works out which window cells count.
// ----------------------------------------------------------------------------
module bblur_front #(
	parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                                     clk,
	input  wire logic                                     arst_n,
	input  wire logic                                     cfg_write,
	input  wire logic [bblur_pkg::CFG_IDX_W-1:0]          cfg_index,
	input  wire logic [bblur_pkg::CFG_W-1:0]              cfg_data,
	input  wire logic                                     in_valid,
	input  wire logic                                     in_stall,
	input  wire logic                                     cmd,
	input  wire logic [bblur_pkg::CH_W-1:0]               red_in,
	input  wire logic [bblur_pkg::CH_W-1:0]               green_in,
	input  wire logic [bblur_pkg::CH_W-1:0]               blue_in,
	output logic                                          push_valid,
	output logic [$clog2(MAX_WIDTH)-1:0]                  push_col,
	output logic [bblur_pkg::PIX_W-1:0]                   push_px,
	output bblur_pkg::bblur_ctl_t                         push_ctl
);
	import bblur_pkg::*;

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int WID_W = $clog2(MAX_WIDTH + 1);
	localparam int RX_W  = ROW_W + 1;

	logic [FW_W-1:0]  fw_q;
	logic [FH_W-1:0]  fh_q;
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;

	logic [WID_W-1:0] eff_w;
	logic [FH_W-1:0]  eff_h;
	logic [WID_W-1:0] col_inc;
	logic [3:0]       row_in;
	logic             accept;
	logic             draining;
	logic             col0;
	logic             wrap;
	logic             last;

	always_comb begin
		priority if (fw_q == '0) eff_w = WID_W'(1);
		else if (32'(fw_q) > 32'(MAX_WIDTH)) eff_w = WID_W'(MAX_WIDTH);
		else eff_w = WID_W'(fw_q);
		priority if (fh_q == '0) eff_h = FH_W'(1);
		else if (32'(fh_q) > 32'(MAX_HEIGHT)) eff_h = FH_W'(MAX_HEIGHT);
		else eff_h = fh_q;
	end

	// row_in[d]: row (current - d) lies inside the frame
	always_comb begin
		for (int d = 0; d < 4; d++) begin
			row_in[d] = (RX_W'(row_q) >= RX_W'(d)) && (RX_W'(row_q) < RX_W'(eff_h) + RX_W'(d));
		end
	end

	assign accept   = in_valid && !in_stall;
	assign draining = RX_W'(row_q) >= RX_W'(eff_h);
	assign col0     = col_q == '0;
	assign col_inc  = WID_W'(col_q) + WID_W'(1);
	assign wrap     = col_inc >= eff_w;
	// final pixel leaves on the first column two rows below the frame
	assign last     = col0 && (RX_W'(row_q) == RX_W'(eff_h) + RX_W'(1));

	assign push_valid = accept && (draining || (cmd != CMD_DRAIN));
	assign push_col   = col_q;
	assign push_px    = draining ? '0 : {red_in, green_in, blue_in};

	always_comb begin
		push_ctl.row_ok[0] = col0 ? row_in[3] : row_in[2];
		push_ctl.row_ok[1] = col0 ? row_in[2] : row_in[1];
		push_ctl.row_ok[2] = col0 ? row_in[1] : row_in[0];
		push_ctl.emit      = push_ctl.row_ok[1];
		push_ctl.last      = last;
		// at the first column the window still holds the end of the row above
		push_ctl.col_ok[0] = col0 ? (eff_w >= WID_W'(2)) : (col_q >= COL_W'(2));
		push_ctl.col_ok[1] = 1'b1;
		push_ctl.col_ok[2] = !col0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q  <= FW_W'(FRAME_WIDTH_RST);
			fh_q  <= FH_W'(FRAME_HEIGHT_RST);
			col_q <= '0;
			row_q <= '0;
		end else if (cfg_write) begin
			unique case (cfg_index)
				REG_FRAME_WIDTH:  fw_q <= cfg_data[FW_W-1:0];
				REG_FRAME_HEIGHT: fh_q <= cfg_data[FH_W-1:0];
			endcase
			// restart the frame
			col_q <= '0;
			row_q <= '0;
		end else if (push_valid) begin
			if (last) begin
				col_q <= '0;
				row_q <= '0;
			end else if (wrap) begin
				col_q <= '0;
				row_q <= row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

// ===== sv/bblur_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_queue: short request queue between front and back
// Register-based FIFO; full holds off the front, the back pops at will.
// ----------------------------------------------------------------------------
module bblur_queue #(
	parameter int DATA_W = 32
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              push,
	input  wire logic [DATA_W-1:0] push_data,
	output logic                   full,
	input  wire logic              pop,
	output logic                   pop_valid,
	output logic [DATA_W-1:0]      pop_data
);
	import bblur_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0] entry_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_W-1:0]  count_q;

	assign full      = count_q == CNT_W'(QUEUE_DEPTH);
	assign pop_valid = count_q != '0;
	assign pop_data  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			priority if (push && !pop) count_q <= count_q + CNT_W'(1);
			else if (pop && !push) count_q <= count_q - CNT_W'(1);
		end
	end

endmodule
`default_nettype wire

// ===== sv/bblur_back.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_back: line store, 3x3 window and rounded mean
// Stage 1 reads the line store, stage 2 shifts the window and writes the
// store back, stage 3 sums the window, the output stage divides.
// ----------------------------------------------------------------------------
module bblur_back #(
	parameter int MAX_WIDTH = bblur_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            q_valid,
	input  wire logic [$clog2(MAX_WIDTH)-1:0]    q_col,
	input  wire logic [bblur_pkg::PIX_W-1:0]     q_px,
	input  wire bblur_pkg::bblur_ctl_t           q_ctl,
	output logic                                 q_pop,
	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [bblur_pkg::CH_W-1:0]           red_out,
	output logic [bblur_pkg::CH_W-1:0]           green_out,
	output logic [bblur_pkg::CH_W-1:0]           blue_out,
	output logic                                 frame_end
);
	import bblur_pkg::*;

	localparam int COL_W  = $clog2(MAX_WIDTH);
	localparam int LINE_W = 2 * PIX_W;
	localparam int PROD_W = NUM_W + RECIP_W;

	logic adv;

	// line store: upper half two rows up, lower half one row up
	logic [LINE_W-1:0] line_mem_q [MAX_WIDTH];
	logic [LINE_W-1:0] wr_data_q;

	logic              valid_s1;
	logic [COL_W-1:0]  col_s1;
	logic [PIX_W-1:0]  px_s1;
	bblur_ctl_t        ctl_s1;
	logic              fwd_s1;
	logic [LINE_W-1:0] rd_s1;
	logic [LINE_W-1:0] line_s1;
	logic [LINE_W-1:0] wr_line;
	logic              wr_en;

	logic [2:0][PIX_W-1:0] win_q [3];
	logic                  valid_s2;
	logic [2:0]            row_ok_s2;
	logic [2:0]            col_ok_s2;
	logic                  last_s2;

	logic [SUM_W-1:0] sum_r;
	logic [SUM_W-1:0] sum_g;
	logic [SUM_W-1:0] sum_b;
	logic [CNT_W-1:0] cnt;

	logic             valid_s3;
	logic [SUM_W-1:0] sum_r_s3;
	logic [SUM_W-1:0] sum_g_s3;
	logic [SUM_W-1:0] sum_b_s3;
	logic [CNT_W-1:0] cnt_s3;
	logic             last_s3;

	logic [RECIP_W-1:0] recip;
	logic [PROD_W-1:0]  prod_r;
	logic [PROD_W-1:0]  prod_g;
	logic [PROD_W-1:0]  prod_b;

	logic             out_valid_q;
	logic [CH_W-1:0]  red_q;
	logic [CH_W-1:0]  green_q;
	logic [CH_W-1:0]  blue_q;
	logic             last_q;

	// the whole pipe moves while the output register is free or being taken
	assign adv   = !out_valid_q || !out_stall;
	assign q_pop = adv && q_valid;
	assign wr_en = adv && valid_s1;

	// a pop at the address being written this cycle takes the written value
	assign line_s1 = fwd_s1 ? wr_data_q : rd_s1;
	assign wr_line = {line_s1[PIX_W-1:0], px_s1};

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_s1 <= line_mem_q[q_col];
		end
		if (wr_en) begin
			line_mem_q[col_s1] <= wr_line;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			valid_s2    <= 1'b0;
			valid_s3    <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (adv) begin
			valid_s1    <= q_valid;
			valid_s2    <= valid_s1 && ctl_s1.emit;
			valid_s3    <= valid_s2;
			out_valid_q <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			col_s1 <= q_col;
			px_s1  <= q_px;
			ctl_s1 <= q_ctl;
			fwd_s1 <= valid_s1 && (col_s1 == q_col);
		end
		if (wr_en) begin
			wr_data_q <= wr_line;
			win_q[0]  <= win_q[1];
			win_q[1]  <= win_q[2];
			win_q[2]  <= {px_s1, line_s1[PIX_W-1:0], line_s1[LINE_W-1:PIX_W]};
			row_ok_s2 <= ctl_s1.row_ok;
			col_ok_s2 <= ctl_s1.col_ok;
			last_s2   <= ctl_s1.last;
		end
	end

	always_comb begin
		sum_r = '0;
		sum_g = '0;
		sum_b = '0;
		for (int k = 0; k < 3; k++) begin
			for (int s = 0; s < 3; s++) begin
				if (col_ok_s2[k] && row_ok_s2[s]) begin
					sum_r = sum_r + SUM_W'(win_q[k][s][2*CH_W +: CH_W]);
					sum_g = sum_g + SUM_W'(win_q[k][s][CH_W +: CH_W]);
					sum_b = sum_b + SUM_W'(win_q[k][s][0 +: CH_W]);
				end
			end
		end
		cnt = CNT_W'($countones(row_ok_s2) * $countones(col_ok_s2));
	end

	always_ff @(posedge clk) begin
		if (adv && valid_s2) begin
			sum_r_s3 <= sum_r;
			sum_g_s3 <= sum_g;
			sum_b_s3 <= sum_b;
			cnt_s3   <= cnt;
			last_s3  <= last_s2;
		end
	end

	// floor((2*sum + n) / (2*n)) by reciprocal multiply
	assign recip  = recip_of(cnt_s3);
	assign prod_r = PROD_W'({sum_r_s3, 1'b0} + NUM_W'(cnt_s3)) * PROD_W'(recip);
	assign prod_g = PROD_W'({sum_g_s3, 1'b0} + NUM_W'(cnt_s3)) * PROD_W'(recip);
	assign prod_b = PROD_W'({sum_b_s3, 1'b0} + NUM_W'(cnt_s3)) * PROD_W'(recip);

	always_ff @(posedge clk) begin
		if (adv && valid_s3) begin
			red_q   <= prod_r[RECIP_SH +: CH_W];
			green_q <= prod_g[RECIP_SH +: CH_W];
			blue_q  <= prod_b[RECIP_SH +: CH_W];
			last_q  <= last_s3;
		end
	end

	assign out_valid = out_valid_q;
	assign red_out   = red_q;
	assign green_out = green_q;
	assign blue_out  = blue_q;
	assign frame_end = last_q;

endmodule
`default_nettype wire

// ===== sv/bblur_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// bblur_checker: port-level assertions for the box blur core
// Watches the request and result channels and the back-pressure they cause.
// ----------------------------------------------------------------------------
module bblur_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        in_valid,
	input wire logic                        in_stall,
	input wire logic                        out_valid,
	input wire logic                        out_stall,
	input wire logic [bblur_pkg::CH_W-1:0]  red_out,
	input wire logic [bblur_pkg::CH_W-1:0]  green_out,
	input wire logic [bblur_pkg::CH_W-1:0]  blue_out,
	input wire logic                        frame_end
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red_out) && $stable(green_out)
			&& $stable(blue_out) && $stable(frame_end))
		else $error("stalled result changed");

	// intake only backs up behind a held result
	a_stall_needs_result: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("in_stall without a pending result");

	// the queue fills only through accepted requests
	a_stall_from_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> $past(in_stall) || $past(in_valid && !in_stall))
		else $error("in_stall rose without a request");

	// with the output free, a full queue does not stay full
	a_free_output_frees_intake: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |=> !in_stall)
		else $error("in_stall held with output free");

endmodule

bind box_blur_3x3_rgb_core bblur_checker u_bblur_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_box_blur_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_checker: prediction and comparison for the 3x3 RGB box blur
// Follows the size writes and every accepted request, keeps its own row
// stores and window, and compares each accepted result in order with the
// oldest predicted pixel. Passes the failure count and the number of
// outstanding pixels to the testbench top.
// ----------------------------------------------------------------------------
module tb_box_blur_checker #(
	parameter int MAX_W = bblur_pkg::MAX_WIDTH_DEF
) (
	input  wire logic                             clk,
	input  wire logic                             arst_n,
	input  wire logic                             cfg_write,
	input  wire logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bblur_pkg::CFG_W-1:0]      cfg_data,
	input  wire logic                             in_valid,
	input  wire logic                             in_stall,
	input  wire logic                             cmd,
	input  wire logic [bblur_pkg::CH_W-1:0]       red_in,
	input  wire logic [bblur_pkg::CH_W-1:0]       green_in,
	input  wire logic [bblur_pkg::CH_W-1:0]       blue_in,
	input  wire logic                             out_valid,
	input  wire logic                             out_stall,
	input  wire logic [bblur_pkg::CH_W-1:0]       red_out,
	input  wire logic [bblur_pkg::CH_W-1:0]       green_out,
	input  wire logic [bblur_pkg::CH_W-1:0]       blue_out,
	input  wire logic                             frame_end,
	output int                                    fail_cnt,
	output int                                    pending_cnt
);

	typedef struct packed {
		logic [bblur_pkg::CH_W-1:0] red;
		logic [bblur_pkg::CH_W-1:0] green;
		logic [bblur_pkg::CH_W-1:0] blue;
		logic                       last;
	} blur_px_t;

	logic [bblur_pkg::PIX_W-1:0] upper_row [MAX_W];   // two rows up
	logic [bblur_pkg::PIX_W-1:0] prev_row [MAX_W];    // one row up
	logic [bblur_pkg::PIX_W-1:0] win [3][3];          // [column][row], oldest column first
	logic [bblur_pkg::FW_W-1:0]  width_reg;
	logic [bblur_pkg::FH_W-1:0]  height_reg;
	int                          col_pos;
	int                          row_pos;
	blur_px_t                    blurred_due [$];

	function automatic int size_used(input int v, input int top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	function automatic logic [bblur_pkg::CH_W-1:0] rounded_mean(input int unsigned sum,
			input int unsigned n);
		int unsigned q;
		q = (2 * sum + n) / (2 * n);
		return q[bblur_pkg::CH_W-1:0];
	endfunction

	// Advance the window by one request and queue the pixel it releases, if any.
	task automatic blur_request(input logic c, input logic [bblur_pkg::PIX_W-1:0] px_in);
		int w, h, cc, row, rbase, qr, qc, first, ncols, cx, ry, k, s;
		int unsigned sr, sg, sb, n;
		logic [bblur_pkg::PIX_W-1:0] px, p;
		logic flushing;
		blur_px_t res;
		w = size_used(int'(width_reg), MAX_W);
		h = size_used(int'(height_reg), bblur_pkg::MAX_HEIGHT);
		flushing = (row_pos >= h);
		// drop drain ticks while pixels of the frame are still due
		if (!flushing && c == bblur_pkg::CMD_DRAIN)
			return;
		px = flushing ? '0 : px_in;
		cc = (col_pos >= w) ? w - 1 : col_pos;
		for (k = 0; k < 2; k++)
			for (s = 0; s < 3; s++)
				win[k][s] = win[k + 1][s];
		win[2][0] = upper_row[cc];
		win[2][1] = prev_row[cc];
		win[2][2] = px;
		upper_row[cc] = prev_row[cc];
		prev_row[cc] = px;
		row = row_pos;
		if (cc >= 1) begin
			ncols = 3;
			first = cc - 2;
			rbase = row - 2;
			qc = cc - 1;
		end else begin
			// column zero closes the previous row: only its last two columns count
			ncols = 2;
			first = w - 2;
			rbase = row - 3;
			qc = w - 1;
		end
		qr = rbase + 1;
		col_pos = cc + 1;
		if (col_pos >= w) begin
			col_pos = 0;
			row_pos++;
		end
		if (qr < 0 || qr >= h)
			return;
		sr = 0;
		sg = 0;
		sb = 0;
		n = 0;
		for (k = 0; k < ncols; k++) begin
			cx = first + k;
			if (cx >= 0 && cx < w) begin
				for (s = 0; s < 3; s++) begin
					ry = rbase + s;
					if (ry >= 0 && ry < h) begin
						p = win[k][s];
						sr += 32'(p[23:16]);
						sg += 32'(p[15:8]);
						sb += 32'(p[7:0]);
						n++;
					end
				end
			end
		end
		if (n == 0)
			n = 1;
		res.red = rounded_mean(sr, n);
		res.green = rounded_mean(sg, n);
		res.blue = rounded_mean(sb, n);
		res.last = (qr == h - 1) && (qc == w - 1);
		blurred_due.push_back(res);
		pending_cnt++;
		if (res.last) begin
			col_pos = 0;
			row_pos = 0;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		blur_px_t got, want;
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				for (int s = 0; s < 3; s++)
					win[k][s] = '0;
			width_reg = bblur_pkg::FW_W'(bblur_pkg::FRAME_WIDTH_RST);
			height_reg = bblur_pkg::FH_W'(bblur_pkg::FRAME_HEIGHT_RST);
			col_pos = 0;
			row_pos = 0;
			blurred_due.delete();
			pending_cnt = 0;
			fail_cnt = 0;
		end else begin
			if (cfg_write) begin
				if (cfg_index == bblur_pkg::REG_FRAME_WIDTH)
					width_reg = cfg_data[bblur_pkg::FW_W-1:0];
				else
					height_reg = cfg_data[bblur_pkg::FH_W-1:0];
				col_pos = 0;
				row_pos = 0;
			end
			if (out_valid && !out_stall) begin
				got = {red_out, green_out, blue_out, frame_end};
				if (blurred_due.size() == 0) begin
					if (fail_cnt < 10)
						$display("%0t: result with nothing due: rgb %h %h %h end %b",
							$time, red_out, green_out, blue_out, frame_end);
					fail_cnt++;
				end else begin
					want = blurred_due.pop_front();
					pending_cnt--;
					if (got !== want) begin
						if (fail_cnt < 10)
							$display("%0t: blurred pixel mismatch: ", $time,
								"expected rgb %h %h %h end %b, ",
								want.red, want.green, want.blue, want.last,
								"got rgb %h %h %h end %b",
								red_out, green_out, blue_out, frame_end);
						fail_cnt++;
					end
				end
			end
			if (in_valid && !in_stall)
				blur_request(cmd, {red_in, green_in, blue_in});
		end
	end

endmodule

// ===== tb/sv/tb_box_blur_3x3_rgb_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_box_blur_3x3_rgb_core: stimulus and verdict for the 3x3 RGB box blur
// Runs two small hand-built frames, out-of-range size writes, then random
// frames with drain noise, dropped pixels, cut-short frames and partial
// flushes, under random idling on both channels. Checking lives in
// tb_box_blur_checker.
// ----------------------------------------------------------------------------
module tb_box_blur_3x3_rgb_core;

	localparam logic CMD_PIXEL    = ~bblur_pkg::CMD_DRAIN;
	localparam int   RUN_LIMIT    = 400000;
	localparam int   SETTLE       = 32;
	localparam int   RANDOM_ITEMS = 1050;

	logic                             clk = 1'b0;
	logic                             arst_n = 1'b0;
	logic                             cfg_write = 1'b0;
	logic [bblur_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [bblur_pkg::CFG_W-1:0]      cfg_data = '0;
	logic                             in_valid = 1'b0;
	logic                             in_stall;
	logic                             cmd = CMD_PIXEL;
	logic [bblur_pkg::CH_W-1:0]       red_in = '0;
	logic [bblur_pkg::CH_W-1:0]       green_in = '0;
	logic [bblur_pkg::CH_W-1:0]       blue_in = '0;
	logic                             out_valid;
	logic                             out_stall = 1'b0;
	logic [bblur_pkg::CH_W-1:0]       red_out;
	logic [bblur_pkg::CH_W-1:0]       green_out;
	logic [bblur_pkg::CH_W-1:0]       blue_out;
	logic                             frame_end;

	int fail_cnt;
	int pending_cnt;
	int cycle_cnt = 0;
	int send_idle_pct = 20;
	int stall_pct = 57;
	int cur_w = bblur_pkg::FRAME_WIDTH_RST;
	int cur_h = bblur_pkg::FRAME_HEIGHT_RST;
	int fed = 0;   // requests the block acts on

	box_blur_3x3_rgb_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.cmd       (cmd),
		.red_in    (red_in),
		.green_in  (green_in),
		.blue_in   (blue_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.red_out   (red_out),
		.green_out (green_out),
		.blue_out  (blue_out),
		.frame_end (frame_end)
	);

	tb_box_blur_checker blur_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_write   (cfg_write),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.cmd         (cmd),
		.red_in      (red_in),
		.green_in    (green_in),
		.blue_in     (blue_in),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.red_out     (red_out),
		.green_out   (green_out),
		.blue_out    (blue_out),
		.frame_end   (frame_end),
		.fail_cnt    (fail_cnt),
		.pending_cnt (pending_cnt)
	);

	always #5 clk = ~clk;

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == RUN_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	function automatic logic [bblur_pkg::CH_W-1:0] rand_chan();
		case ($urandom_range(0, 7))
			0: begin
				return 8'h00;
			end
			1: begin
				return 8'hFF;
			end
			default: begin
				return 8'($urandom_range(0, 255));
			end
		endcase
	endfunction

	function automatic int size_in_use(input int v, input int top);
		if (v == 0)
			return 1;
		if (v > top)
			return top;
		return v;
	endfunction

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_req(input logic c, input logic [7:0] r, input logic [7:0] g,
			input logic [7:0] b);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= c;
		red_in <= r;
		green_in <= g;
		blue_in <= b;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		@(negedge clk);
		while (pending_cnt != 0)
			@(negedge clk);
	endtask

	task automatic set_sizes(input bit do_w, input int w_data, input bit do_h, input int h_data);
		hold_until_drained();
		// let requests that release nothing clear the pipeline first
		repeat (SETTLE) @(negedge clk);
		if (do_w) begin
			cfg_write <= 1'b1;
			cfg_index <= bblur_pkg::REG_FRAME_WIDTH;
			cfg_data <= bblur_pkg::CFG_W'(w_data);
			@(negedge clk);
			cur_w = size_in_use(w_data & 'h7FF, bblur_pkg::MAX_WIDTH_DEF);
		end
		if (do_h) begin
			cfg_write <= 1'b1;
			cfg_index <= bblur_pkg::REG_FRAME_HEIGHT;
			cfg_data <= bblur_pkg::CFG_W'(h_data);
			@(negedge clk);
			cur_h = size_in_use(h_data & 'h1FFF, bblur_pkg::MAX_HEIGHT);
		end
		cfg_write <= 1'b0;
	endtask

	task automatic send_frame(input int npx, input int nflush, input bit pause);
		int i;
		for (i = 0; i < npx; i++) begin
			if ($urandom_range(0, 15) == 0)
				send_req(bblur_pkg::CMD_DRAIN, rand_chan(), rand_chan(), rand_chan());
			send_req(CMD_PIXEL, rand_chan(), rand_chan(), rand_chan());
			fed++;
		end
		for (i = 0; i < nflush; i++) begin
			if (pause && i == nflush / 2)
				hold_until_drained();
			// a pixel sent here is dropped and acts as a drain tick
			send_req(($urandom_range(0, 3) == 0) ? CMD_PIXEL : bblur_pkg::CMD_DRAIN,
				rand_chan(), rand_chan(), rand_chan());
			fed++;
		end
	endtask

	initial begin
		int w, h, npx, nflush, sel;
		bit must_cfg, first;
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// 3x3 frame: corners, edges and the centre give divisors 4, 6 and 9
		set_sizes(1, 3, 1, 3);
		send_req(bblur_pkg::CMD_DRAIN, 8'hFF, 8'hFF, 8'hFF);   // idle drain, ignored
		send_req(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		send_req(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
		send_req(CMD_PIXEL, 8'hFF, 8'h00, 8'h80);
		send_req(bblur_pkg::CMD_DRAIN, 8'h00, 8'hFF, 8'h00);   // drain inside the frame
		send_req(CMD_PIXEL, 8'h01, 8'h02, 8'h03);
		send_req(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		send_req(CMD_PIXEL, 8'h00, 8'h00, 8'h00);
		send_req(CMD_PIXEL, 8'hAA, 8'h55, 8'hFF);
		send_req(CMD_PIXEL, 8'h55, 8'hAA, 8'h00);
		send_req(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		send_req(bblur_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
		send_req(CMD_PIXEL, 8'h12, 8'h34, 8'h56);              // dropped during the flush
		send_req(bblur_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
		send_req(bblur_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
		// single-pixel frame: divisor 1
		set_sizes(1, 1, 1, 1);
		send_req(CMD_PIXEL, 8'hC8, 8'h64, 8'h32);
		send_req(bblur_pkg::CMD_DRAIN, 8'h00, 8'h00, 8'h00);
		send_req(CMD_PIXEL, 8'hFF, 8'hFF, 8'hFF);

		// oversized writes clamp to the largest frame: nothing may leave early
		set_sizes(1, 'h1FFF, 1, 'h1FFF);
		send_frame(40, 0, 0);
		// zero sizes act as one
		set_sizes(1, 0, 1, 0);
		send_frame(cur_w * cur_h, cur_w + 1, 1);

		fed = 0;
		must_cfg = 1;
		first = 1;
		while (fed < RANDOM_ITEMS) begin
			if (fed < RANDOM_ITEMS / 3) begin
				send_idle_pct = 20;
				stall_pct = 57;
			end else if (fed < 2 * RANDOM_ITEMS / 3) begin
				send_idle_pct = 57;
				stall_pct = 20;
			end else begin
				send_idle_pct = 0;
				stall_pct = 0;
			end
			if (must_cfg || $urandom_range(0, 2) == 0) begin
				w = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 64) : $urandom_range(1, 12);
				h = (w > 12) ? $urandom_range(1, 4) : $urandom_range(1, 10);
				if ($urandom_range(0, 19) == 0)
					w = 0;
				if ($urandom_range(0, 19) == 0)
					h = 0;
				sel = $urandom_range(0, 2);
				set_sizes(sel != 2, w, sel != 1, h);
			end
			npx = cur_w * cur_h;
			nflush = cur_w + 1;
			must_cfg = 0;
			case ($urandom_range(0, 9))
				0: begin
					// cut the frame short, then restart it with a size write
					npx = $urandom_range(0, npx - 1);
					nflush = 0;
					must_cfg = 1;
				end
				1: begin
					// stop part-way through the flush
					nflush = $urandom_range(0, cur_w);
					must_cfg = 1;
				end
				default: begin
				end
			endcase
			send_frame(npx, nflush, first || $urandom_range(0, 5) == 0);
			first = 0;
		end

		hold_until_drained();
		repeat (SETTLE) @(negedge clk);
		if (fail_cnt == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/bblur_pkg.sv
sv/bblur_front.sv
sv/bblur_queue.sv
sv/bblur_back.sv
sv/box_blur_3x3_rgb_core.sv
sv/bblur_checker.sv
tb/sv/tb_box_blur_checker.sv
tb/sv/tb_box_blur_3x3_rgb_core.sv
